### rtl/sit_pkg.sv
package sit_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  localparam int DW        = CW + 1;
  localparam int PW        = 2 * DW;
  localparam int TW        = PW + 1;
  localparam int LOW       = 34;
  localparam int QB        = 34;
  localparam int DENW      = TW + 1;
  localparam int NW        = 104;
  localparam int EW        = 16;
  localparam int THW       = EW + FRAC_BITS;
  localparam int SW        = ((FRAC_BITS > EW) ? FRAC_BITS : EW) + 2;
  localparam int AW        = DW + 1;
  localparam int AXW       = SW + AW + 2;
  localparam int FW        = QB + 2;
  localparam int SUMW      = FW + 1;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic signed [CW-1:0] x3;
    logic signed [CW-1:0] y3;
    logic signed [CW-1:0] x4;
    logic signed [CW-1:0] y4;
    logic                 strict;
  } seg_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QB-1:0] quo;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    seg_t            seg;
    logic            meet;
    logic [DENW-1:0] den;
    lane_t           lx;
    lane_t           ly;
  } div_t;

endpackage

### rtl/sit_front.sv
module sit_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sit_pkg::seg_t             seg_i,
  input  logic [sit_pkg::EW-1:0]    eps_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sit_pkg::div_t             div_o
);

  localparam int NS   = 7;
  localparam int CW   = sit_pkg::CW;
  localparam int DW   = sit_pkg::DW;
  localparam int PW   = sit_pkg::PW;
  localparam int TW   = sit_pkg::TW;
  localparam int LOW  = sit_pkg::LOW;
  localparam int NW   = sit_pkg::NW;
  localparam int PLW  = DW + LOW + 1;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [NS-1:0] vin;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    vin = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= vin[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage A: differences
  sit_pkg::seg_t         seg_a_q;
  logic signed [DW-1:0]  dx1_a_q, dy1_a_q, dx2_a_q, dy2_a_q, ax_a_q, ay_a_q;
  logic signed [DW-1:0]  dx1_d, dy1_d, dx2_d, dy2_d, ax_d, ay_d;

  always_comb begin
    dx1_d = {seg_i.x2[CW-1], seg_i.x2} - {seg_i.x1[CW-1], seg_i.x1};
    dy1_d = {seg_i.y2[CW-1], seg_i.y2} - {seg_i.y1[CW-1], seg_i.y1};
    dx2_d = {seg_i.x4[CW-1], seg_i.x4} - {seg_i.x3[CW-1], seg_i.x3};
    dy2_d = {seg_i.y4[CW-1], seg_i.y4} - {seg_i.y3[CW-1], seg_i.y3};
    ax_d  = {seg_i.x3[CW-1], seg_i.x3} - {seg_i.x1[CW-1], seg_i.x1};
    ay_d  = {seg_i.y3[CW-1], seg_i.y3} - {seg_i.y1[CW-1], seg_i.y1};
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      seg_a_q <= seg_i;
      dx1_a_q <= dx1_d;
      dy1_a_q <= dy1_d;
      dx2_a_q <= dx2_d;
      dy2_a_q <= dy2_d;
      ax_a_q  <= ax_d;
      ay_a_q  <= ay_d;
    end
  end

  // stage B: cross products
  sit_pkg::seg_t         seg_b_q;
  logic signed [DW-1:0]  dx1_b_q, dy1_b_q;
  logic signed [PW-1:0]  p0_b_q, p1_b_q, p2_b_q, p3_b_q;
  logic signed [PW-1:0]  p0_d, p1_d, p2_d, p3_d;

  always_comb begin
    p0_d = dx1_a_q * dy2_a_q;
    p1_d = dy1_a_q * dx2_a_q;
    p2_d = ax_a_q * dy2_a_q;
    p3_d = ay_a_q * dx2_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      seg_b_q <= seg_a_q;
      dx1_b_q <= dx1_a_q;
      dy1_b_q <= dy1_a_q;
      p0_b_q  <= p0_d;
      p1_b_q  <= p1_d;
      p2_b_q  <= p2_d;
      p3_b_q  <= p3_d;
    end
  end

  // stage C: determinant and numerator
  sit_pkg::seg_t         seg_c_q;
  logic signed [DW-1:0]  dx1_c_q, dy1_c_q;
  logic signed [TW-1:0]  td_c_q, tn_c_q;
  logic signed [TW-1:0]  td_d, tn_d;

  always_comb begin
    td_d = TW'(p0_b_q) - TW'(p1_b_q);
    tn_d = TW'(p2_b_q) - TW'(p3_b_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      seg_c_q <= seg_b_q;
      dx1_c_q <= dx1_b_q;
      dy1_c_q <= dy1_b_q;
      td_c_q  <= td_d;
      tn_c_q  <= tn_d;
    end
  end

  // stage D: make the determinant positive, test it against epsilon
  sit_pkg::seg_t         seg_d_q;
  logic signed [DW-1:0]  dx1_d_q, dy1_d_q;
  logic signed [TW-1:0]  td_d_q, tn_d_q;
  logic                  meet_d_q;
  logic signed [TW-1:0]  tdn_d, tnn_d;
  logic                  meet_d;
  logic [sit_pkg::THW-1:0] thr;

  always_comb begin
    thr   = sit_pkg::THW'(eps_i) << sit_pkg::FRAC_BITS;
    tdn_d = td_c_q[TW-1] ? -td_c_q : td_c_q;
    tnn_d = td_c_q[TW-1] ? -tn_c_q : tn_c_q;
    meet_d = (td_c_q != '0) && ($unsigned(tdn_d) >= TW'(thr));
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      seg_d_q  <= seg_c_q;
      dx1_d_q  <= dx1_c_q;
      dy1_d_q  <= dy1_c_q;
      td_d_q   <= tdn_d;
      tn_d_q   <= tnn_d;
      meet_d_q <= meet_d;
    end
  end

  // stage E: partial products of the crossing offset
  sit_pkg::seg_t         seg_e_q;
  logic                  meet_e_q;
  logic signed [TW-1:0]  td_e_q;
  logic signed [PLW-1:0] plx_e_q, ply_e_q;
  logic signed [PW-1:0]  phx_e_q, phy_e_q;
  logic signed [PLW-1:0] plx_d, ply_d;
  logic signed [PW-1:0]  phx_d, phy_d;

  always_comb begin
    plx_d = dx1_d_q * $signed({1'b0, tn_d_q[LOW-1:0]});
    ply_d = dy1_d_q * $signed({1'b0, tn_d_q[LOW-1:0]});
    phx_d = dx1_d_q * $signed(tn_d_q[TW-1:LOW]);
    phy_d = dy1_d_q * $signed(tn_d_q[TW-1:LOW]);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      seg_e_q  <= seg_d_q;
      meet_e_q <= meet_d_q;
      td_e_q   <= td_d_q;
      plx_e_q  <= plx_d;
      ply_e_q  <= ply_d;
      phx_e_q  <= phx_d;
      phy_e_q  <= phy_d;
    end
  end

  // stage F: rounding numerator 2*n + d
  sit_pkg::seg_t         seg_f_q;
  logic                  meet_f_q;
  logic signed [TW-1:0]  td_f_q;
  logic signed [NW-1:0]  numx_f_q, numy_f_q;
  logic signed [NW-1:0]  nx_d, ny_d, numx_d, numy_d;

  always_comb begin
    nx_d   = (NW'(phx_e_q) <<< LOW) + NW'(plx_e_q);
    ny_d   = (NW'(phy_e_q) <<< LOW) + NW'(ply_e_q);
    numx_d = (nx_d <<< 1) + NW'(td_e_q);
    numy_d = (ny_d <<< 1) + NW'(td_e_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      seg_f_q  <= seg_e_q;
      meet_f_q <= meet_e_q;
      td_f_q   <= td_e_q;
      numx_f_q <= numx_d;
      numy_f_q <= numy_d;
    end
  end

  // stage G: magnitude and quotient range check
  sit_pkg::div_t           div_q;
  sit_pkg::div_t           div_d;
  logic [NW-1:0]           lim_d;

  always_comb begin
    div_d.seg  = seg_f_q;
    div_d.meet = meet_f_q;
    div_d.den  = {td_f_q, 1'b0};
    lim_d      = NW'(div_d.den) << sit_pkg::QB;
    div_d.lx.neg = numx_f_q[NW-1];
    div_d.ly.neg = numy_f_q[NW-1];
    div_d.lx.rem = numx_f_q[NW-1] ? $unsigned(-numx_f_q) : $unsigned(numx_f_q);
    div_d.ly.rem = numy_f_q[NW-1] ? $unsigned(-numy_f_q) : $unsigned(numy_f_q);
    div_d.lx.quo = '0;
    div_d.ly.quo = '0;
    div_d.lx.ovf = div_d.lx.rem >= lim_d;
    div_d.ly.ovf = div_d.ly.rem >= lim_d;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) div_q <= div_d;
  end

  assign div_o = div_q;

endmodule

### rtl/sit_div.sv
module sit_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sit_pkg::div_t div_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sit_pkg::div_t div_o
);

  localparam int NS = sit_pkg::QB;
  localparam int NW = sit_pkg::NW;

  function automatic sit_pkg::lane_t div_step(sit_pkg::lane_t l,
                                              logic [sit_pkg::DENW-1:0] den,
                                              int unsigned b);
    logic [NW-1:0]  sd;
    sit_pkg::lane_t r;
    sd = NW'(den) << b;
    r  = l;
    if (l.rem >= sd) begin
      r.rem    = l.rem - sd;
      r.quo[b] = 1'b1;
    end
    return r;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [NS-1:0] vin;
  sit_pkg::div_t st_q [NS];
  sit_pkg::div_t src  [NS];
  sit_pkg::div_t st_d [NS];

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    vin = {v_q[NS-2:0], in_valid_i};
    src[0] = div_i;
    for (int k = 1; k < NS; k++) begin
      src[k] = st_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      st_d[k]    = src[k];
      st_d[k].lx = div_step(src[k].lx, src[k].den, NS - 1 - k);
      st_d[k].ly = div_step(src[k].ly, src[k].den, NS - 1 - k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign div_o       = st_q[NS-1];

endmodule

### rtl/sit_back.sv
module sit_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sit_pkg::div_t                 div_i,
  input  logic [sit_pkg::EW-1:0]        eps_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          lines_meet_o,
  output logic                          hit_o,
  output logic signed [sit_pkg::CW-1:0] cross_x_o,
  output logic signed [sit_pkg::CW-1:0] cross_y_o
);

  localparam int NS   = 4;
  localparam int CW   = sit_pkg::CW;
  localparam int DW   = sit_pkg::DW;
  localparam int PW   = sit_pkg::PW;
  localparam int TW   = sit_pkg::TW;
  localparam int AW   = sit_pkg::AW;
  localparam int SW   = sit_pkg::SW;
  localparam int AXW  = sit_pkg::AXW;
  localparam int FW   = sit_pkg::FW;
  localparam int SUMW = sit_pkg::SUMW;
  localparam int FB   = sit_pkg::FRAC_BITS;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] val;
    logic                 inr;
  } rs_t;

  function automatic rs_t round_sat(sit_pkg::lane_t l, logic signed [CW-1:0] base);
    logic [FW-1:0]          mag;
    logic signed [FW-1:0]   fl;
    logic signed [SUMW-1:0] sum;
    rs_t                    r;
    mag = FW'(l.quo) + FW'(l.neg && (l.rem != '0));
    fl  = l.neg ? -$signed(mag) : $signed(mag);
    sum = SUMW'(base) + SUMW'(fl);
    r.inr = 1'b0;
    if (l.ovf) begin
      r.val = l.neg ? CMIN : CMAX;
    end else if (sum > SUMW'(CMAX)) begin
      r.val = CMAX;
    end else if (sum < SUMW'(CMIN)) begin
      r.val = CMIN;
    end else begin
      r.val = sum[CW-1:0];
      r.inr = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sdiff(logic signed [CW-1:0] a,
                                                 logic signed [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic [AW-1:0] absv(logic signed [DW-1:0] v);
    logic signed [AW-1:0] t;
    t = AW'(v);
    return v[DW-1] ? $unsigned(-t) : $unsigned(t);
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [NS-1:0] vin;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    vin = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= vin[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  logic [sit_pkg::THW-1:0] thr;
  assign thr = sit_pkg::THW'(eps_i) << FB;

  // stage R: round, saturate
  sit_pkg::seg_t        seg_r_q;
  logic                 meet_r_q, inr_r_q;
  logic signed [CW-1:0] cx_r_q, cy_r_q;
  rs_t                  rx_d, ry_d;

  always_comb begin
    rx_d = round_sat(div_i.lx, div_i.seg.x1);
    ry_d = round_sat(div_i.ly, div_i.seg.y1);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      seg_r_q  <= div_i.seg;
      meet_r_q <= div_i.meet;
      inr_r_q  <= rx_d.inr && ry_d.inr;
      cx_r_q   <= rx_d.val;
      cy_r_q   <= ry_d.val;
    end
  end

  // stage H1: offsets against both segments
  logic                 meet_1_q, inr_1_q, strict_1_q;
  logic signed [CW-1:0] cx_1_q, cy_1_q;
  logic signed [DW-1:0] sex_1_q [2], sey_1_q [2], sax_1_q [2], say_1_q [2];
  logic                 deg_1_q [2], dacc_1_q [2], flx_1_q [2], fly_1_q [2];
  logic signed [AW-1:0] anx_1_q [2], aex_1_q [2], any_1_q [2], aey_1_q [2];

  logic signed [CW-1:0] sx [2], sy [2], ex [2], ey [2];
  logic signed [DW-1:0] sex_d [2], sey_d [2], sax_d [2], say_d [2];
  logic                 deg_d [2], dacc_d [2], flx_d [2], fly_d [2];
  logic signed [AW-1:0] anx_d [2], aex_d [2], any_d [2], aey_d [2];

  always_comb begin
    sx[0] = seg_r_q.x1;
    sy[0] = seg_r_q.y1;
    ex[0] = seg_r_q.x2;
    ey[0] = seg_r_q.y2;
    sx[1] = seg_r_q.x3;
    sy[1] = seg_r_q.y3;
    ex[1] = seg_r_q.x4;
    ey[1] = seg_r_q.y4;
    for (int s = 0; s < 2; s++) begin
      sex_d[s]  = sdiff(ex[s], sx[s]);
      sey_d[s]  = sdiff(ey[s], sy[s]);
      sax_d[s]  = sdiff(cx_r_q, sx[s]);
      say_d[s]  = sdiff(cy_r_q, sy[s]);
      deg_d[s]  = (absv(sex_d[s]) < AW'(eps_i)) && (absv(sey_d[s]) < AW'(eps_i));
      dacc_d[s] = !seg_r_q.strict && (absv(sax_d[s]) < AW'(eps_i))
                  && (absv(say_d[s]) < AW'(eps_i));
      flx_d[s]  = (sex_d[s] == '0) || (absv(sex_d[s]) < AW'(eps_i));
      fly_d[s]  = (sey_d[s] == '0) || (absv(sey_d[s]) < AW'(eps_i));
      anx_d[s]  = sex_d[s][DW-1] ? -AW'(sax_d[s]) : AW'(sax_d[s]);
      aex_d[s]  = sex_d[s][DW-1] ? -AW'(sex_d[s]) : AW'(sex_d[s]);
      any_d[s]  = sey_d[s][DW-1] ? -AW'(say_d[s]) : AW'(say_d[s]);
      aey_d[s]  = sey_d[s][DW-1] ? -AW'(sey_d[s]) : AW'(sey_d[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      meet_1_q   <= meet_r_q;
      inr_1_q    <= inr_r_q;
      strict_1_q <= seg_r_q.strict;
      cx_1_q     <= cx_r_q;
      cy_1_q     <= cy_r_q;
      for (int s = 0; s < 2; s++) begin
        sex_1_q[s]  <= sex_d[s];
        sey_1_q[s]  <= sey_d[s];
        sax_1_q[s]  <= sax_d[s];
        say_1_q[s]  <= say_d[s];
        deg_1_q[s]  <= deg_d[s];
        dacc_1_q[s] <= dacc_d[s];
        flx_1_q[s]  <= flx_d[s];
        fly_1_q[s]  <= fly_d[s];
        anx_1_q[s]  <= anx_d[s];
        aex_1_q[s]  <= aex_d[s];
        any_1_q[s]  <= any_d[s];
        aey_1_q[s]  <= aey_d[s];
      end
    end
  end

  // stage H2: products
  logic                  meet_2_q, inr_2_q;
  logic signed [CW-1:0]  cx_2_q, cy_2_q;
  logic                  deg_2_q [2], dacc_2_q [2], flx_2_q [2], fly_2_q [2];
  logic signed [PW-1:0]  m0_2_q [2], m1_2_q [2];
  logic signed [AXW-1:0] lox_2_q [2], hix_2_q [2], scx_2_q [2];
  logic signed [AXW-1:0] loy_2_q [2], hiy_2_q [2], scy_2_q [2];

  logic signed [SW-1:0]  tmin_d, tmax_d;
  logic signed [PW-1:0]  m0_d [2], m1_d [2];
  logic signed [AXW-1:0] lox_d [2], hix_d [2], scx_d [2];
  logic signed [AXW-1:0] loy_d [2], hiy_d [2], scy_d [2];

  always_comb begin
    tmin_d = strict_1_q ? $signed(SW'(eps_i)) : '0;
    tmax_d = (SW'(1) <<< FB) - tmin_d;
    for (int s = 0; s < 2; s++) begin
      m0_d[s]  = sax_1_q[s] * sey_1_q[s];
      m1_d[s]  = say_1_q[s] * sex_1_q[s];
      lox_d[s] = tmin_d * aex_1_q[s];
      hix_d[s] = tmax_d * aex_1_q[s];
      scx_d[s] = AXW'(anx_1_q[s]) <<< FB;
      loy_d[s] = tmin_d * aey_1_q[s];
      hiy_d[s] = tmax_d * aey_1_q[s];
      scy_d[s] = AXW'(any_1_q[s]) <<< FB;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      meet_2_q <= meet_1_q;
      inr_2_q  <= inr_1_q;
      cx_2_q   <= cx_1_q;
      cy_2_q   <= cy_1_q;
      for (int s = 0; s < 2; s++) begin
        deg_2_q[s]  <= deg_1_q[s];
        dacc_2_q[s] <= dacc_1_q[s];
        flx_2_q[s]  <= flx_1_q[s];
        fly_2_q[s]  <= fly_1_q[s];
        m0_2_q[s]   <= m0_d[s];
        m1_2_q[s]   <= m1_d[s];
        lox_2_q[s]  <= lox_d[s];
        hix_2_q[s]  <= hix_d[s];
        scx_2_q[s]  <= scx_d[s];
        loy_2_q[s]  <= loy_d[s];
        hiy_2_q[s]  <= hiy_d[s];
        scy_2_q[s]  <= scy_d[s];
      end
    end
  end

  // stage H3: collinearity, axis windows, output word
  logic                 meet_3_q, hit_3_q;
  logic signed [CW-1:0] cx_3_q, cy_3_q;
  logic signed [TW-1:0] det_d [2];
  logic [TW-1:0]        adet_d [2];
  logic                 ok_d [2];
  logic                 hit_d;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      det_d[s]  = TW'(m0_2_q[s]) - TW'(m1_2_q[s]);
      adet_d[s] = det_d[s][TW-1] ? $unsigned(-det_d[s]) : $unsigned(det_d[s]);
      if (deg_2_q[s]) begin
        ok_d[s] = dacc_2_q[s];
      end else begin
        ok_d[s] = (adet_d[s] < TW'(thr))
                  && (flx_2_q[s] || ((lox_2_q[s] <= scx_2_q[s])
                                      && (scx_2_q[s] <= hix_2_q[s])))
                  && (fly_2_q[s] || ((loy_2_q[s] <= scy_2_q[s])
                                      && (scy_2_q[s] <= hiy_2_q[s])));
      end
    end
    hit_d = inr_2_q && ok_d[0] && ok_d[1];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      meet_3_q <= meet_2_q;
      hit_3_q  <= meet_2_q && hit_d;
      cx_3_q   <= meet_2_q ? cx_2_q : '0;
      cy_3_q   <= meet_2_q ? cy_2_q : '0;
    end
  end

  assign lines_meet_o = meet_3_q;
  assign hit_o        = hit_3_q;
  assign cross_x_o    = cx_3_q;
  assign cross_y_o    = cy_3_q;

endmodule

### rtl/segment_intersection_test.sv
// Segment intersection test, signed Q16.16 endpoints.
// Input channel: in_valid_i / in_stall_o carry one word of two segments
// and a strict flag; a word is taken at a clock edge with in_valid_i high
// and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry lines_meet, hit and the
// saturated crossing point, one result word for every input word, in order.
// The pipeline has 7 front stages (differences, cross products,
// determinant, sign and epsilon test, partial products, rounding numerator,
// range check), 34 stages of the pipelined divider at one quotient bit each,
// and 4 back stages (round and saturate, segment offsets, products, window
// compares).
// Throughput is one word per cycle while out_stall_i is low.
// When out_stall_i is high the last stage holds; empty stages upstream keep
// filling, and in_stall_o rises only once every stage holds a word.
// Reset empties the pipeline and sets epsilon to 1.
// cfg_we_i writes epsilon from cfg_wdata_i; write it only while the
// pipeline is empty.
module segment_intersection_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sit_pkg::EW-1:0]        cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [sit_pkg::CW-1:0] seg1_start_x_i,
  input  logic signed [sit_pkg::CW-1:0] seg1_start_y_i,
  input  logic signed [sit_pkg::CW-1:0] seg1_end_x_i,
  input  logic signed [sit_pkg::CW-1:0] seg1_end_y_i,
  input  logic signed [sit_pkg::CW-1:0] seg2_start_x_i,
  input  logic signed [sit_pkg::CW-1:0] seg2_start_y_i,
  input  logic signed [sit_pkg::CW-1:0] seg2_end_x_i,
  input  logic signed [sit_pkg::CW-1:0] seg2_end_y_i,
  input  logic                          strict_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          lines_meet_o,
  output logic                          hit_o,
  output logic signed [sit_pkg::CW-1:0] cross_x_o,
  output logic signed [sit_pkg::CW-1:0] cross_y_o
);

  logic [sit_pkg::EW-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= sit_pkg::EW'(1);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  sit_pkg::seg_t seg;

  always_comb begin
    seg.x1     = seg1_start_x_i;
    seg.y1     = seg1_start_y_i;
    seg.x2     = seg1_end_x_i;
    seg.y2     = seg1_end_y_i;
    seg.x3     = seg2_start_x_i;
    seg.y3     = seg2_start_y_i;
    seg.x4     = seg2_end_x_i;
    seg.y4     = seg2_end_y_i;
    seg.strict = strict_i;
  end

  logic          in_ready;
  logic          f_valid, f_ready, d_valid, d_ready;
  sit_pkg::div_t f_word, d_word;

  sit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .seg_i       (seg),
    .eps_i       (eps_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .div_o       (f_word)
  );

  sit_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .div_i       (f_word),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .div_o       (d_word)
  );

  sit_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (d_valid),
    .in_ready_o   (d_ready),
    .div_i        (d_word),
    .eps_i        (eps_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (!out_stall_i),
    .lines_meet_o (lines_meet_o),
    .hit_o        (hit_o),
    .cross_x_o    (cross_x_o),
    .cross_y_o    (cross_y_o)
  );

  assign in_stall_o = !in_ready;

endmodule
